@@ rtl/chrt_pkg.sv @@
`default_nettype none

package chrt_pkg;

    localparam int BUCKETS = 64;
    localparam int SLOTS   = 128;

    localparam int ACT_W    = 2;
    localparam int KEY_W    = 8;
    localparam int SVC_W    = 16;
    localparam int LINK_W   = 8;
    localparam int BUCKET_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int HASH_W   = 13;
    localparam int STEP_W   = 4;

    localparam int HASH_SRC_MUL = 7;
    localparam int HASH_TGT_MUL = 13;

    localparam logic [LINK_W-1:0] NIL_LINK   = 8'hFF;
    localparam logic [LINK_W-1:0] SLOT_LIMIT = LINK_W'(SLOTS);

    localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FIND   = 2'd2;

    typedef logic [STEP_W-1:0] step_t;

    // microprogram addresses
    localparam step_t S_FETCH   = 4'd0;
    localparam step_t S_DECODE  = 4'd1;
    localparam step_t S_WINIT   = 4'd2;
    localparam step_t S_CHECK   = 4'd3;
    localparam step_t S_MATCH   = 4'd4;
    localparam step_t S_HIT     = 4'd5;
    localparam step_t S_UNLINK  = 4'd6;
    localparam step_t S_FOUND   = 4'd7;
    localparam step_t S_ADD     = 4'd8;
    localparam step_t S_ADDWR   = 4'd9;
    localparam step_t S_FAIL    = 4'd10;
    localparam step_t S_DONE    = 4'd11;

    typedef enum logic [3:0] {
        C_NEVER    = 4'd0,
        C_ALWAYS   = 4'd1,
        C_IN_TAKE  = 4'd2,
        C_IS_ADD   = 4'd3,
        C_NOT_WALK = 4'd4,
        C_LINK_BAD = 4'd5,
        C_KEY_MISS = 4'd6,
        C_IS_FIND  = 4'd7,
        C_FULL     = 4'd8,
        C_OUT_FREE = 4'd9
    } cond_t;

    typedef enum logic [2:0] {
        R_NONE   = 3'd0,
        R_FAIL   = 3'd1,
        R_ADD    = 3'd2,
        R_FIND   = 3'd3,
        R_REMOVE = 3'd4
    } res_t;

    typedef struct packed {
        cond_t cond;
        step_t jmp;
        logic  stay;
        logic  take_in;
        logic  walk_init;
        logic  slot_rd;
        logic  adv_on_miss;
        logic  add_wr;
        logic  unlink_wr;
        res_t  res;
        logic  post;
    } ctrl_t;

    typedef struct packed {
        logic in_take;
        logic is_add;
        logic is_walk;
        logic link_bad;
        logic key_miss;
        logic is_find;
        logic full;
        logic out_free;
    } flags_t;

    // BUCKETS is a power of two, so the remainder is a mask
    function automatic logic [BUCKET_W-1:0] bucket_of(input logic [KEY_W-1:0] s,
                                                      input logic [KEY_W-1:0] t);
        logic [HASH_W-1:0] sum;
        logic [HASH_W-1:0] rem;
        sum = HASH_W'(s) * HASH_W'(HASH_SRC_MUL) + HASH_W'(t) * HASH_W'(HASH_TGT_MUL);
        rem = sum % HASH_W'(BUCKETS);
        return rem[BUCKET_W-1:0];
    endfunction

    // control store: jump taken when cond holds, else stay or fall through
    function automatic ctrl_t ucode_rom(input step_t s);
        ctrl_t w;
        w      = '0;
        w.cond = C_ALWAYS;
        w.jmp  = S_FETCH;
        w.res  = R_NONE;
        unique case (s)
            S_FETCH:
            begin
                w.take_in = 1'b1;
                w.cond    = C_IN_TAKE;
                w.jmp     = S_DECODE;
                w.stay    = 1'b1;
            end
            S_DECODE:
            begin
                w.cond = C_IS_ADD;
                w.jmp  = S_ADD;
            end
            S_WINIT:
            begin
                w.walk_init = 1'b1;
                w.cond      = C_NOT_WALK;
                w.jmp       = S_FAIL;
            end
            S_CHECK:
            begin
                w.slot_rd = 1'b1;
                w.cond    = C_LINK_BAD;
                w.jmp     = S_FAIL;
            end
            S_MATCH:
            begin
                w.adv_on_miss = 1'b1;
                w.cond        = C_KEY_MISS;
                w.jmp         = S_CHECK;
            end
            S_HIT:
            begin
                w.cond = C_IS_FIND;
                w.jmp  = S_FOUND;
            end
            S_UNLINK:
            begin
                w.unlink_wr = 1'b1;
                w.res       = R_REMOVE;
                w.jmp       = S_DONE;
            end
            S_FOUND:
            begin
                w.res = R_FIND;
                w.jmp = S_DONE;
            end
            S_ADD:
            begin
                w.cond = C_FULL;
                w.jmp  = S_FAIL;
            end
            S_ADDWR:
            begin
                w.add_wr = 1'b1;
                w.res    = R_ADD;
                w.jmp    = S_DONE;
            end
            S_FAIL:
            begin
                w.res  = R_FAIL;
                w.cond = C_NEVER;
            end
            S_DONE:
            begin
                w.post = 1'b1;
                w.cond = C_OUT_FREE;
                w.jmp  = S_FETCH;
                w.stay = 1'b1;
            end
            default:
            begin
                w.jmp = S_FETCH;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ rtl/chrt_sequencer.sv @@
`default_nettype none

module chrt_sequencer (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire chrt_pkg::flags_t flags,
    output chrt_pkg::ctrl_t      ctrl
);

    chrt_pkg::step_t step_reg;
    chrt_pkg::step_t step_next;
    logic            cond_hit;

    assign ctrl = chrt_pkg::ucode_rom(step_reg);

    always_comb
    begin
        unique case (ctrl.cond)
            chrt_pkg::C_NEVER:    cond_hit = 1'b0;
            chrt_pkg::C_ALWAYS:   cond_hit = 1'b1;
            chrt_pkg::C_IN_TAKE:  cond_hit = flags.in_take;
            chrt_pkg::C_IS_ADD:   cond_hit = flags.is_add;
            chrt_pkg::C_NOT_WALK: cond_hit = !flags.is_walk;
            chrt_pkg::C_LINK_BAD: cond_hit = flags.link_bad;
            chrt_pkg::C_KEY_MISS: cond_hit = flags.key_miss;
            chrt_pkg::C_IS_FIND:  cond_hit = flags.is_find;
            chrt_pkg::C_FULL:     cond_hit = flags.full;
            chrt_pkg::C_OUT_FREE: cond_hit = flags.out_free;
            default:              cond_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        if (cond_hit)
        begin
            step_next = ctrl.jmp;
        end
        else if (ctrl.stay)
        begin
            step_next = step_reg;
        end
        else
        begin
            step_next = step_reg + chrt_pkg::STEP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= chrt_pkg::S_FETCH;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    a_take_to_decode: assert property (@(posedge clk) disable iff (!rst_n)
        flags.in_take |=> step_reg == chrt_pkg::S_DECODE)
        else $error("accepted word did not move to decode");

    a_step_in_program: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= chrt_pkg::S_DONE)
        else $error("step counter left the program");

    a_done_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == chrt_pkg::S_DONE && flags.out_free) |=> step_reg == chrt_pkg::S_FETCH)
        else $error("result posted but sequencer did not return to fetch");

endmodule

`default_nettype wire

@@ rtl/chrt_datapath.sv @@
`default_nettype none

module chrt_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire chrt_pkg::ctrl_t               ctrl,
    output chrt_pkg::flags_t                   flags,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [chrt_pkg::ACT_W-1:0]    action,
    input  wire logic [chrt_pkg::KEY_W-1:0]    source_id,
    input  wire logic [chrt_pkg::KEY_W-1:0]    target_id,
    input  wire logic [chrt_pkg::SVC_W-1:0]    service_code,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               success,
    output logic [chrt_pkg::SVC_W-1:0]         found_service,
    output logic [chrt_pkg::LINK_W-1:0]        slot_index
);

    // bucket heads and slot store
    logic [chrt_pkg::LINK_W-1:0]  head_mem [chrt_pkg::BUCKETS];
    logic [chrt_pkg::BUCKETS-1:0] head_vld_reg;
    logic [2*chrt_pkg::KEY_W-1:0] key_mem  [chrt_pkg::SLOTS];
    logic [chrt_pkg::SVC_W-1:0]   svc_mem  [chrt_pkg::SLOTS];
    logic [chrt_pkg::LINK_W-1:0]  nxt_mem  [chrt_pkg::SLOTS];

    logic [chrt_pkg::LINK_W-1:0]  head_rd_reg;
    logic                         head_vrd_reg;
    logic [2*chrt_pkg::KEY_W-1:0] key_rd_reg;
    logic [chrt_pkg::SVC_W-1:0]   svc_rd_reg;
    logic [chrt_pkg::LINK_W-1:0]  nxt_rd_reg;

    logic [chrt_pkg::ACT_W-1:0]    act_reg;
    logic [chrt_pkg::KEY_W-1:0]    src_reg;
    logic [chrt_pkg::KEY_W-1:0]    tgt_reg;
    logic [chrt_pkg::SVC_W-1:0]    svc_reg;
    logic [chrt_pkg::BUCKET_W-1:0] bkt_reg;
    logic [chrt_pkg::LINK_W-1:0]   cur_reg;
    logic [chrt_pkg::LINK_W-1:0]   prev_reg;
    logic                          prev_head_reg;
    logic [chrt_pkg::LINK_W-1:0]   used_reg;
    logic [chrt_pkg::LINK_W-1:0]   used_next;

    logic                          res_ok_reg;
    logic [chrt_pkg::SVC_W-1:0]    res_svc_reg;
    logic [chrt_pkg::LINK_W-1:0]   res_slot_reg;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          ok_out_reg;
    logic [chrt_pkg::SVC_W-1:0]    svc_out_reg;
    logic [chrt_pkg::LINK_W-1:0]   slot_out_reg;

    logic                          in_take;
    logic                          out_free;
    logic                          out_load;
    logic [chrt_pkg::BUCKET_W-1:0] in_bkt;
    logic [chrt_pkg::LINK_W-1:0]   head_val;
    logic [2*chrt_pkg::KEY_W-1:0]  key_cur;
    logic                          key_miss;
    logic                          head_we;
    logic [chrt_pkg::LINK_W-1:0]   head_wd;
    logic                          nxt_we;
    logic [chrt_pkg::SLOT_W-1:0]   nxt_wa;
    logic [chrt_pkg::LINK_W-1:0]   nxt_wd;

    assign in_stall = !ctrl.take_in;
    assign in_take  = in_valid && ctrl.take_in;
    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = ctrl.post && out_free;
    assign in_bkt   = chrt_pkg::bucket_of(source_id, target_id);

    // a head never written reads as an empty chain
    assign head_val = head_vrd_reg ? head_rd_reg : chrt_pkg::NIL_LINK;
    assign key_cur  = {src_reg, tgt_reg};
    assign key_miss = key_rd_reg != key_cur;

    always_comb
    begin
        flags.in_take  = in_take;
        flags.is_add   = act_reg == chrt_pkg::ACT_ADD;
        flags.is_walk  = act_reg == chrt_pkg::ACT_REMOVE || act_reg == chrt_pkg::ACT_FIND;
        flags.link_bad = cur_reg == chrt_pkg::NIL_LINK || cur_reg >= used_reg
                         || cur_reg >= chrt_pkg::SLOT_LIMIT;
        flags.key_miss = key_miss;
        flags.is_find  = act_reg == chrt_pkg::ACT_FIND;
        flags.full     = used_reg >= chrt_pkg::SLOT_LIMIT;
        flags.out_free = out_free;
    end

    // write port selection: add links a new slot at the head, remove bypasses one
    always_comb
    begin
        head_we = ctrl.add_wr || (ctrl.unlink_wr && prev_head_reg);
        head_wd = ctrl.add_wr ? used_reg : nxt_rd_reg;
        nxt_we  = ctrl.add_wr || (ctrl.unlink_wr && !prev_head_reg);
        nxt_wa  = ctrl.add_wr ? used_reg[chrt_pkg::SLOT_W-1:0]
                              : prev_reg[chrt_pkg::SLOT_W-1:0];
        nxt_wd  = ctrl.add_wr ? head_val : nxt_rd_reg;
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[bkt_reg] <= head_wd;
        end
        if (in_take)
        begin
            head_rd_reg <= head_mem[in_bkt];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_vld_reg <= '0;
            head_vrd_reg <= 1'b0;
        end
        else
        begin
            if (head_we)
            begin
                head_vld_reg[bkt_reg] <= 1'b1;
            end
            if (in_take)
            begin
                head_vrd_reg <= head_vld_reg[in_bkt];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.add_wr)
        begin
            key_mem[used_reg[chrt_pkg::SLOT_W-1:0]] <= key_cur;
            svc_mem[used_reg[chrt_pkg::SLOT_W-1:0]] <= svc_reg;
        end
        if (nxt_we)
        begin
            nxt_mem[nxt_wa] <= nxt_wd;
        end
        if (ctrl.slot_rd)
        begin
            key_rd_reg <= key_mem[cur_reg[chrt_pkg::SLOT_W-1:0]];
            svc_rd_reg <= svc_mem[cur_reg[chrt_pkg::SLOT_W-1:0]];
            nxt_rd_reg <= nxt_mem[cur_reg[chrt_pkg::SLOT_W-1:0]];
        end
    end

    // captured word and chain walk pointers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            act_reg <= action;
            src_reg <= source_id;
            tgt_reg <= target_id;
            svc_reg <= service_code;
            bkt_reg <= in_bkt;
        end
        if (ctrl.walk_init)
        begin
            cur_reg       <= head_val;
            prev_head_reg <= 1'b1;
        end
        else if (ctrl.adv_on_miss && key_miss)
        begin
            prev_reg      <= cur_reg;
            prev_head_reg <= 1'b0;
            cur_reg       <= nxt_rd_reg;
        end
    end

    assign used_next = used_reg + chrt_pkg::LINK_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (ctrl.add_wr)
        begin
            used_reg <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (ctrl.res)
            chrt_pkg::R_FAIL:
            begin
                res_ok_reg   <= 1'b0;
                res_svc_reg  <= '0;
                res_slot_reg <= '0;
            end
            chrt_pkg::R_ADD:
            begin
                res_ok_reg   <= 1'b1;
                res_svc_reg  <= '0;
                res_slot_reg <= used_reg;
            end
            chrt_pkg::R_FIND:
            begin
                res_ok_reg   <= 1'b1;
                res_svc_reg  <= svc_rd_reg;
                res_slot_reg <= cur_reg;
            end
            chrt_pkg::R_REMOVE:
            begin
                res_ok_reg   <= 1'b1;
                res_svc_reg  <= '0;
                res_slot_reg <= cur_reg;
            end
            default:
            begin
                res_ok_reg   <= res_ok_reg;
            end
        endcase
    end

    // output word register
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            ok_out_reg   <= res_ok_reg;
            svc_out_reg  <= res_svc_reg;
            slot_out_reg <= res_slot_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign success       = ok_out_reg;
    assign found_service = svc_out_reg;
    assign slot_index    = slot_out_reg;

    a_add_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.add_wr |-> used_reg < chrt_pkg::SLOT_LIMIT)
        else $error("slot written with the table full");

    a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= chrt_pkg::SLOT_LIMIT)
        else $error("slot count beyond capacity");

    a_unlink_on_match: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.unlink_wr |-> !key_miss)
        else $error("unlink without a key match");

    a_post_shows: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg)
        else $error("posted result not presented");

endmodule

`default_nettype wire

@@ rtl/chained_hash_route_table.sv @@
`default_nettype none

// channel   direction  handshake            word
// in        input      in_valid / in_stall  action, source_id, target_id, service_code
// out       output     out_valid / out_stall success, found_service, slot_index
//
// one word at a time; add, full table and unused action go from fetch to posting with no chain walk
// remove and find walk the chain slot by slot: each slot visited needs
// a read of the slot store and a key compare before the next link is known
// reset clears the step counter, slot count, output valid and head valid bits
// a new word is taken while the previous result still waits in the output register
// a stalled result holds the sequencer in its posting step

module chained_hash_route_table (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [chrt_pkg::ACT_W-1:0]    action,
    input  wire logic [chrt_pkg::KEY_W-1:0]    source_id,
    input  wire logic [chrt_pkg::KEY_W-1:0]    target_id,
    input  wire logic [chrt_pkg::SVC_W-1:0]    service_code,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               success,
    output logic [chrt_pkg::SVC_W-1:0]         found_service,
    output logic [chrt_pkg::LINK_W-1:0]        slot_index
);

    chrt_pkg::ctrl_t  ctrl;
    chrt_pkg::flags_t flags;

    chrt_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    chrt_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .flags         (flags),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .source_id     (source_id),
        .target_id     (target_id),
        .service_code  (service_code),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .success       (success),
        .found_service (found_service),
        .slot_index    (slot_index)
    );

endmodule

`default_nettype wire
